/* hdl/status_byte_and_error_queue_top_assert.svh */
// Assertion macros for the status byte and error queue block.
`ifndef STATUS_BYTE_AND_ERROR_QUEUE_TOP_ASSERT_SVH
`define STATUS_BYTE_AND_ERROR_QUEUE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SBEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbeq assertion failed");
`define SBEQ_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sbeq forbidden condition seen");
`else
`define SBEQ_ASSERT(label, clk, rst, prop)
`define SBEQ_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* hdl/sbeq_pkg.sv */
// Types, bit positions and error class decode shared by the status block.
package sbeq_pkg;

   typedef enum logic [2:0] {
      REQ_PUSH   = 3'd0,
      REQ_LATCH  = 3'd1,
      REQ_POP    = 3'd2,
      REQ_STATUS = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_code_type;

   localparam logic CSR_EVENT_ENABLE   = 1'b0;
   localparam logic CSR_SERVICE_ENABLE = 1'b1;

   // Standard event status bits
   localparam logic [7:0] ESR_OPC = 8'h01;
   localparam logic [7:0] ESR_RQC = 8'h02;
   localparam logic [7:0] ESR_QYE = 8'h04;
   localparam logic [7:0] ESR_DDE = 8'h08;
   localparam logic [7:0] ESR_EXE = 8'h10;
   localparam logic [7:0] ESR_CME = 8'h20;
   localparam logic [7:0] ESR_URQ = 8'h40;
   localparam logic [7:0] ESR_PON = 8'h80;

   // Status byte bits
   localparam logic [7:0] STB_EAV = 8'h04;
   localparam logic [7:0] STB_QSB = 8'h08;
   localparam logic [7:0] STB_MAV = 8'h10;
   localparam logic [7:0] STB_ESB = 8'h20;
   localparam logic [7:0] STB_MSS = 8'h40;
   localparam logic [7:0] STB_OSB = 8'h80;

   localparam logic signed [15:0] OVERFLOW_CODE = -16'sd350;

   // Map an error number to the event status bit of its class.
   function automatic logic [7:0] class_bit(input logic signed [15:0] n);
      logic [7:0] bit_out;
      if (n == 16'sd0)               bit_out = 8'h00;
      else if (n > 16'sd0)           bit_out = ESR_DDE;
      else if (n > -16'sd200)        bit_out = ESR_CME;
      else if (n > -16'sd300)        bit_out = ESR_EXE;
      else if (n > -16'sd400)        bit_out = ESR_DDE;
      else if (n > -16'sd500)        bit_out = ESR_QYE;
      else if (n > -16'sd600)        bit_out = ESR_PON;
      else if (n > -16'sd700)        bit_out = ESR_URQ;
      else if (n > -16'sd800)        bit_out = ESR_RQC;
      else if (n > -16'sd900)        bit_out = ESR_OPC;
      else                           bit_out = 8'h00;
      return bit_out;
   endfunction

endpackage

/* hdl/sbeq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sbeq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/status_byte_and_error_queue_top.sv */
// Top level of the status byte, event status register and error queue block.
// The response strobe rises in the cycle after start is taken.
// Throughput: one request per cycle, with busy low outside reset; the error queue
//   RAM has one write and one registered read port, which serves a pop in one pass.
// Reset: synchronous, active high; clears queue pointers, event status, both
//   enable masks and the response strobe. The queue RAM is not cleared.
// The receiver cannot stall: every response shows for exactly one cycle.
`include "status_byte_and_error_queue_top_assert.svh"

module status_byte_and_error_queue_top
   import sbeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic signed [15:0] req_error_number,
   input  logic [7:0]         req_event_bits,
   input  logic [7:0]         req_summary_bits,
   // response channel
   output logic               rsp_valid,
   output logic signed [15:0] rsp_popped_number,
   output logic               rsp_popped_ok,
   output logic [7:0]         rsp_status_byte,
   output logic [7:0]         rsp_event_status,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [7:0]         csr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // Queue pointers and status registers
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    event_ff, event_in;
   logic [7:0]    event_enable_ff;
   logic [7:0]    service_enable_ff;

   // Response registers
   logic          valid_ff;
   logic          popped_ok_ff, popped_ok_in;
   logic [7:0]    status_byte_ff, status_byte_in;

   // Queue RAM ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [15:0]   rd_data;

   logic          accept;
   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail_addr;
   logic [AW-1:0] newest_addr;
   logic [7:0]    stb;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   // Next free slot: head plus fill count, wrapped once at the queue depth.
   assign tail_sum  = {1'b0, head_ff} + (AW+1)'(count_ff);
   assign tail_addr = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
   // Newest entry of a full queue sits just behind the head.
   assign newest_addr = (head_ff == '0) ? AW'(QUEUE_DEPTH - 1) : head_ff - AW'(1);

   // Decode the request and form the next state of the pointers and registers.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      event_in     = event_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_addr;
      wr_data      = req_error_number;
      rd_en        = 1'b0;
      popped_ok_in = 1'b0;
      if (accept) begin
         unique case (req_type)
            REQ_PUSH: begin
               if (req_error_number != 16'sd0) begin
                  event_in = event_ff | class_bit(req_error_number);
                  wr_en    = 1'b1;
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     // Full queue: drop the number, mark the newest slot as overflow.
                     wr_addr  = newest_addr;
                     wr_data  = OVERFLOW_CODE;
                     event_in = event_ff | class_bit(req_error_number) | ESR_DDE;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            REQ_LATCH: begin
               event_in = event_ff | req_event_bits;
            end
            REQ_POP: begin
               if (count_ff != '0) begin
                  rd_en        = 1'b1;
                  popped_ok_in = 1'b1;
                  count_in     = count_ff - CW'(1);
                  head_in      = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
               end
            end
            REQ_STATUS: begin
               // Read only: the status byte is formed below.
            end
            REQ_CLEAR: begin
               event_in = '0;
               head_in  = '0;
               count_in = '0;
            end
            default: begin
               // Undefined request codes leave the state alone.
            end
         endcase
      end
   end

   // Status byte as it stands after this request.
   always_comb begin
      stb = req_summary_bits & (STB_QSB | STB_MAV | STB_OSB);
      if (count_in != '0) begin
         stb = stb | STB_EAV;
      end
      if ((event_in & event_enable_ff) != 8'h00) begin
         stb = stb | STB_ESB;
      end
      if ((stb & service_enable_ff & ~STB_MSS) != 8'h00) begin
         stb = stb | STB_MSS;
      end
      status_byte_in = stb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff           <= '0;
         count_ff          <= '0;
         event_ff          <= '0;
         event_enable_ff   <= '0;
         service_enable_ff <= '0;
         valid_ff          <= 1'b0;
         popped_ok_ff      <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         event_ff     <= event_in;
         valid_ff     <= accept;
         popped_ok_ff <= popped_ok_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_EVENT_ENABLE:   event_enable_ff   <= csr_data;
               CSR_SERVICE_ENABLE: service_enable_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Hold the status byte for the response cycle.
   always_ff @(posedge clock) begin
      status_byte_ff <= status_byte_in;
   end

   sbeq_ram #(
      .WIDTH (16),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Drive the response; the popped number arrives from the RAM read register.
   assign rsp_valid         = valid_ff;
   assign rsp_popped_ok     = popped_ok_ff;
   assign rsp_popped_number = popped_ok_ff ? $signed(rd_data) : 16'sd0;
   assign rsp_status_byte   = status_byte_ff;
   assign rsp_event_status  = event_ff;

   `SBEQ_ASSERT_NEVER(a_count_in_range, clock, reset, count_ff > CW'(QUEUE_DEPTH))
   `SBEQ_ASSERT_NEVER(a_head_in_range, clock, reset, head_ff > AW'(QUEUE_DEPTH - 1))
   `SBEQ_ASSERT(a_pop_reports, clock, reset,
      (accept && req_type == REQ_POP && count_ff != '0) |=> (rsp_valid && rsp_popped_ok))
   `SBEQ_ASSERT(a_eav_tracks_queue, clock, reset,
      rsp_valid |-> ((rsp_status_byte[2] == 1'b1) == (count_ff != '0)))

endmodule
